### rtl/fdd_pkg.sv
// Package for the feed record descrambler.
// Holds item kinds, register indexes, mode codes and fixed byte constants.
// No dependencies.
package fdd_pkg;

  // Kind of an input beat, carried in tuser
  localparam logic CMD_LEARN = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_PRESET_MASK  = 1'b0;
  localparam logic CFG_PRESET_VALID = 1'b1;

  localparam int unsigned MASK_W = 64;
  localparam int unsigned BYTE_W = 8;

  // Byte constants
  localparam logic [7:0] LEARN_SKIP_BYTE = 8'h7f;
  localparam logic [7:0] LOW_PAIR        = 8'h00;
  localparam logic [7:0] LOW_INVERT      = 8'hff;
  localparam logic [7:0] RUN_OFFSET      = 8'h1c;
  localparam logic [7:0] LEN_EXTENDED    = 8'd24;
  localparam logic [7:0] PAIR_LAST_POS   = 8'd23;
  localparam logic [7:0] PAIR_EXTRA_POS  = 8'd27;
  localparam logic [7:0] INV_LAST_POS    = 8'd19;
  localparam logic [7:0] INV_EXT_POS     = 8'd23;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_PAIR,
    MODE_INVERT,
    MODE_RUN
  } fdd_mode_e;

  // Mode selection handed to the byte transform
  typedef struct packed {
    fdd_mode_e  mode;
    logic [7:0] low;
  } fdd_mode_t;

endpackage

### rtl/fdd_byte_xform.sv
// Per-byte descramble transform for the feed record descrambler.
// Combinational; depends on fdd_pkg for mode codes and constants.
module fdd_byte_xform
  import fdd_pkg::*;
(
  input  fdd_mode_t  mode_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pos_i,
  input  logic [7:0] len_i,
  input  logic [7:0] prev_i,
  output logic [7:0] byte_o
);

  logic       long_rec;
  logic       pair_hit;
  logic       inv_hit;
  logic       run_hit;
  logic [7:0] run_key;

  // Decode which positions each mode touches
  assign long_rec = len_i > LEN_EXTENDED;
  assign pair_hit = ((pos_i[1:0] == 2'b11) && (pos_i <= PAIR_LAST_POS))
                    || ((pos_i == PAIR_EXTRA_POS) && long_rec);
  assign inv_hit  = (pos_i <= INV_LAST_POS) || ((pos_i <= INV_EXT_POS) && long_rec);
  assign run_hit  = !pos_i[0] && (pos_i < len_i);
  assign run_key  = mode_i.low + len_i - RUN_OFFSET - pos_i;

  // Apply the selected mode
  always_comb begin
    byte_o = byte_i;
    case (mode_i.mode)
      MODE_PASS:   byte_o = byte_i;
      MODE_PAIR:   if (pair_hit) byte_o = byte_i ^ prev_i;
      MODE_INVERT: if (inv_hit) byte_o = ~byte_i;
      MODE_RUN:    if (run_hit) byte_o = byte_i ^ run_key;
      default:     byte_o = byte_i;
    endcase
  end

endmodule

### rtl/feed_record_descrambler.sv
// Top level of the feed record descrambler: input register, mask and record
// state, result register. Depends on fdd_pkg and fdd_byte_xform.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_axis   | in        | tvalid/tready      | tdata words+byte+length, tuser kind, tlast
//  m_axis   | out       | tvalid/tready      | tdata plain byte+mask ready, tlast
//  cfg      | in        | cfg_we_i           | cfg_addr_i index, cfg_wdata_i value
//
// One beat per cycle sustained while the result side takes beats; a beat passes
// through the input register, then the result register, and is held in place under
// a stall.
// Record position and previous byte update as the beat leaves the input
// register, so back-to-back bytes of a record see each other's state.
// A stalled result holds; the input side keeps accepting while the result
// register is empty or being taken, or while the input register is empty.
// Reset clears the mask state, record state and both valid flags.
module feed_record_descrambler
  import fdd_pkg::*;
#(
  parameter int unsigned MAX_RECORD_BYTES = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // tdata: known_word[63:0], masked_word[127:64], data_byte[135:128],
  //        record_length[143:136]
  input  logic [143:0]  s_axis_tdata,
  // tuser: cmd
  input  logic          s_axis_tuser,
  input  logic          s_axis_tlast,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: plain_byte[7:0], mask_ready[8], zero fill[15:9]
  output logic [15:0]   m_axis_tdata,
  output logic          m_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_we_i,
  input  logic          cfg_addr_i,
  input  logic [63:0]   cfg_wdata_i
);

  localparam logic [7:0] PosMax = 8'(MAX_RECORD_BYTES);

  // Configuration registers
  logic [63:0] preset_mask_q;
  logic        preset_valid_q;

  // Mask and record state
  logic [63:0] learned_mask_q, learned_mask_d;
  logic        learned_flag_q, learned_flag_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  prev_q, prev_d;

  // Input register
  logic        in_valid_q;
  logic        in_cmd_q;
  logic        in_last_q;
  logic [63:0] in_known_q;
  logic [63:0] in_masked_q;
  logic [7:0]  in_byte_q;
  logic [7:0]  in_len_q;

  // Result register
  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        out_ready_q, out_ready_d;

  logic        advance;
  logic        fire;
  logic        held;
  logic        learn_take;
  logic [63:0] mask;
  fdd_mode_t   mode;
  logic [7:0]  xform_byte;

  // Handshake: the stage moves when the result register is free or drains
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign fire          = in_valid_q && advance;

  // Hold the configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_mask_q  <= '0;
      preset_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PRESET_MASK:  preset_mask_q  <= cfg_wdata_i;
        CFG_PRESET_VALID: preset_valid_q <= cfg_wdata_i[0];
        default:          preset_valid_q <= preset_valid_q;
      endcase
    end
  end

  // Capture an input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q    <= s_axis_tuser;
      in_last_q   <= s_axis_tlast;
      in_known_q  <= s_axis_tdata[63:0];
      in_masked_q <= s_axis_tdata[127:64];
      in_byte_q   <= s_axis_tdata[135:128];
      in_len_q    <= s_axis_tdata[143:136];
    end
  end

  // Select the held mask and its mode
  always_comb begin
    held = preset_valid_q || learned_flag_q;
    mask = preset_valid_q ? preset_mask_q : learned_mask_q;
    mode.low = mask[7:0];
    if (!held || (mask == '0)) begin
      mode.mode = MODE_PASS;
    end else if (mask[7:0] == LOW_PAIR) begin
      mode.mode = MODE_PAIR;
    end else if (mask[7:0] == LOW_INVERT) begin
      mode.mode = MODE_INVERT;
    end else begin
      mode.mode = MODE_RUN;
    end
  end

  fdd_byte_xform u_xform (
    .mode_i (mode),
    .byte_i (in_byte_q),
    .pos_i  (pos_q),
    .len_i  (in_len_q),
    .prev_i (prev_q),
    .byte_o (xform_byte)
  );

  // Learn, advance the record position, form the result
  always_comb begin
    learned_mask_d = learned_mask_q;
    learned_flag_d = learned_flag_q;
    pos_d          = pos_q;
    prev_d         = prev_q;
    learn_take     = !held && (in_known_q[7:0] != LEARN_SKIP_BYTE);
    out_byte_d     = '0;
    out_last_d     = 1'b0;
    out_ready_d    = held;
    case (in_cmd_q)
      CMD_LEARN: begin
        if (learn_take) begin
          learned_mask_d = in_known_q ^ in_masked_q;
          learned_flag_d = 1'b1;
          out_ready_d    = 1'b1;
        end
      end
      CMD_DATA: begin
        out_byte_d = xform_byte;
        out_last_d = in_last_q;
        if (in_last_q) begin
          pos_d  = '0;
          prev_d = '0;
        end else begin
          prev_d = in_byte_q;
          if (pos_q < PosMax) pos_d = pos_q + 8'd1;
        end
      end
      default: out_byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learned_mask_q <= '0;
      learned_flag_q <= 1'b0;
      pos_q          <= '0;
      prev_q         <= '0;
    end else if (fire) begin
      learned_mask_q <= learned_mask_d;
      learned_flag_q <= learned_flag_d;
      pos_q          <= pos_d;
      prev_q         <= prev_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      out_ready_q <= out_ready_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'b0, out_ready_q, out_byte_q};

endmodule

### rtl/fdd_checker.sv
// Port-level checks for the feed record descrambler, bound to the top level.
// Depends only on the top level's ports.
module fdd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [15:0]  m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // A stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped under stall");

  // A stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed under stall");

  // A draining output never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // An accepted beat moves on from the input register into the result register when the output is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat did not reach the output");

endmodule

bind feed_record_descrambler fdd_checker u_fdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

### bench/tb_feed_record_descrambler.sv
// Testbench for feed_record_descrambler: directed checks of the mask sources and byte modes,
// then random records under three idling mixes, checked against an in-bench predictor.
// Depends on fdd_pkg and the feed_record_descrambler RTL only.
`timescale 1ns / 1ps

module tb_feed_record_descrambler;
  import fdd_pkg::*;

  localparam int unsigned MAX_POS      = 255;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned CHUNK_BEATS  = 50;

  // One input beat, unpacked
  typedef struct packed {
    logic        cmd;
    logic [63:0] known;
    logic [63:0] masked;
    logic [7:0]  data;
    logic [7:0]  len;
    logic        eor;
  } beat_t;

  // One result beat
  typedef struct packed {
    logic [7:0] plain;
    logic       last;
    logic       ready;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [143:0] s_axis_tdata = '0;
  logic         s_axis_tuser = CMD_DATA;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_addr_i = CFG_PRESET_MASK;
  logic [63:0]  cfg_wdata_i = '0;

  // Predictor state: registers and descrambler state
  logic [63:0] preset_mask_q   = '0;
  logic        preset_valid_q  = 1'b0;
  logic [63:0] learned_mask_q  = '0;
  logic        learned_q       = 1'b0;
  logic [7:0]  position_q      = '0;
  logic [7:0]  prev_byte_q     = '0;

  result_t results_due[$];
  result_t due;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;
  int      errors = 0;
  int      beats_sent = 0;
  int      results_seen = 0;
  int      cfg_writes = 0;
  int      cycles = 0;
  int      mode_hits[4] = '{0, 0, 0, 0};

  feed_record_descrambler DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_feed_record_descrambler: errors");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result beat with nothing predicted: tdata %h tlast %b", m_axis_tdata,
               m_axis_tlast);
        errors++;
      end else begin
        due = results_due.pop_front();
        if (m_axis_tdata[7:0] !== due.plain) begin
          $error("plain_byte: expected %h, got %h", due.plain, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tlast !== due.last) begin
          $error("last_byte: expected %b, got %b", due.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[8] !== due.ready) begin
          $error("mask_ready: expected %b, got %b", due.ready, m_axis_tdata[8]);
          errors++;
        end
        if (m_axis_tdata[15:9] !== '0) begin
          $error("tdata fill: expected %h, got %h", 7'h0, m_axis_tdata[15:9]);
          errors++;
        end
      end
    end
  end

  // Mode chosen by the mask now held
  function automatic fdd_mode_t active_mode();
    fdd_mode_t   m;
    logic [63:0] mask;
    mask  = preset_valid_q ? preset_mask_q : learned_mask_q;
    m.low = mask[7:0];
    if (!(preset_valid_q || learned_q) || mask == '0) m.mode = MODE_PASS;
    else if (mask[7:0] == LOW_PAIR) m.mode = MODE_PAIR;
    else if (mask[7:0] == LOW_INVERT) m.mode = MODE_INVERT;
    else m.mode = MODE_RUN;
    return m;
  endfunction

  function automatic logic [7:0] unscrambled(fdd_mode_t m, logic [7:0] b, logic [7:0] pos,
                                             logic [7:0] len, logic [7:0] prev);
    logic [7:0] key;
    case (m.mode)
      MODE_PAIR: begin
        if ((pos[1:0] == 2'b11 && pos <= PAIR_LAST_POS) ||
            (pos == PAIR_EXTRA_POS && len > LEN_EXTENDED)) return b ^ prev;
      end
      MODE_INVERT: begin
        if (pos <= INV_LAST_POS || (pos <= INV_EXT_POS && len > LEN_EXTENDED)) return ~b;
      end
      MODE_RUN: begin
        // Key wraps mod 256, so short records give large keys
        if (!pos[0] && pos < len) begin
          key = m.low + len - RUN_OFFSET - pos;
          return b ^ key;
        end
      end
      default: ;
    endcase
    return b;
  endfunction

  // Advance the predictor by one accepted beat and queue its result
  function automatic void predict_beat(beat_t b);
    result_t   r;
    fdd_mode_t m;
    if (b.cmd == CMD_LEARN) begin
      if (!(preset_valid_q || learned_q) && b.known[7:0] != LEARN_SKIP_BYTE) begin
        learned_mask_q = b.known ^ b.masked;
        learned_q      = 1'b1;
      end
      r.plain = '0;
      r.last  = 1'b0;
    end else begin
      m       = active_mode();
      mode_hits[int'(m.mode)]++;
      r.plain = unscrambled(m, b.data, position_q, b.len, prev_byte_q);
      r.last  = b.eor;
      if (b.eor) begin
        position_q  = '0;
        prev_byte_q = '0;
      end else begin
        prev_byte_q = b.data;
        if (position_q < MAX_POS) position_q = position_q + 8'd1;
      end
    end
    r.ready = preset_valid_q || learned_q;
    results_due.push_back(r);
  endfunction

  function automatic beat_t random_beat(logic cmd);
    beat_t b;
    b.cmd    = cmd;
    b.known  = {$urandom, $urandom};
    b.masked = {$urandom, $urandom};
    b.data   = 8'($urandom_range(255));
    b.len    = 8'($urandom_range(255));
    b.eor    = 1'($urandom_range(1));
    // Hit the skip byte now and then
    if (cmd == CMD_LEARN && $urandom_range(3) == 0) b.known[7:0] = LEARN_SKIP_BYTE;
    return b;
  endfunction

  function automatic beat_t data_beat(logic [7:0] data, logic [7:0] len, logic eor);
    beat_t b;
    b      = random_beat(CMD_DATA);
    b.data = data;
    b.len  = len;
    b.eor  = eor;
    return b;
  endfunction

  function automatic beat_t learn_beat(logic [63:0] known, logic [63:0] masked);
    beat_t b;
    b        = random_beat(CMD_LEARN);
    b.known  = known;
    b.masked = masked;
    return b;
  endfunction

  // Send one beat; returns at the edge that accepted it with tvalid still high
  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.len, b.data, b.masked, b.known};
    s_axis_tuser  <= b.cmd;
    s_axis_tlast  <= b.eor;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat(b);
    beats_sent++;
  endtask

  // Hold the input until every predicted result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [63:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PRESET_MASK) preset_mask_q = value;
    else preset_valid_q = value[0];
    cfg_writes++;
  endtask

  // A record of nbytes data beats, all carrying len, with an odd learn beat mixed in
  task automatic send_record(int nbytes, logic [7:0] len);
    int i;
    for (i = 0; i < nbytes; i++) begin
      if ($urandom_range(29) == 0) send_beat(random_beat(CMD_LEARN));
      send_beat(data_beat(8'($urandom_range(255)), len, i == nbytes - 1));
    end
  endtask

  task automatic test_no_mask();
    send_beat(data_beat(8'h00, 8'd0, 1'b0));
    send_beat(data_beat(8'hff, 8'd255, 1'b0));
    send_beat(data_beat(8'($urandom_range(255)), 8'd28, 1'b1));
    send_beat(learn_beat({56'h0123_4567_89ab_cd, LEARN_SKIP_BYTE}, {$urandom, $urandom}));
  endtask

  task automatic test_preset_blocks_learn();
    write_reg(CFG_PRESET_MASK, {56'h0123_4567_89ab_cd, LOW_PAIR});
    write_reg(CFG_PRESET_VALID, 64'd1);
    send_beat(learn_beat(64'h1111_2222_3333_4444, {$urandom, $urandom}));
    send_record(4, 8'd4);
  endtask

  task automatic test_learn_zero_mask();
    write_reg(CFG_PRESET_VALID, 64'd0);
    send_beat(learn_beat(64'hfedc_ba98_7654_3210, 64'hfedc_ba98_7654_3210));
    send_beat(data_beat(8'ha5, 8'd28, 1'b1));
    send_beat(learn_beat(64'h0f0f_0f0f_0f0f_0f01, 64'hf0f0_f0f0_f0f0_f0f0));
  endtask

  task automatic test_invert();
    write_reg(CFG_PRESET_MASK, '1);
    write_reg(CFG_PRESET_VALID, 64'd1);
    send_beat(data_beat(8'h00, 8'd25, 1'b0));
    send_beat(data_beat(8'hff, 8'd25, 1'b1));
  endtask

  task automatic test_running();
    write_reg(CFG_PRESET_MASK, 64'h8000_0000_0000_005a);
    send_beat(data_beat(8'h3c, 8'd2, 1'b0));
    send_beat(learn_beat(64'h0000_0000_0000_0001, 64'h0));
    send_beat(data_beat(8'hc3, 8'd2, 1'b0));
    send_beat(data_beat(8'h99, 8'd2, 1'b1));
  endtask

  // Pick a mask setting for one chunk of random traffic
  task automatic set_random_mask(int sel);
    logic [63:0] mask;
    mask = {$urandom, $urandom};
    case (sel % 6)
      0: mask[7:0] = LOW_PAIR;
      1: mask[7:0] = LOW_INVERT;
      2: mask[7:0] = 8'($urandom_range(254, 1));
      3: mask = '0;
      4: mask = '1;
      default: ;
    endcase
    write_reg(CFG_PRESET_MASK, mask);
    // Last choice falls back on the learned zero mask
    write_reg(CFG_PRESET_VALID, (sel % 6 == 5) ? 64'd0 : 64'd1);
  endtask

  task automatic run_chunk(int sel);
    int start;
    int pick;
    int len;
    set_random_mask(sel);
    start = beats_sent;
    // One overlong record drives the position into saturation
    if (sel == 1) send_record(int'($urandom_range(270, 256)), 8'($urandom_range(255)));
    while (beats_sent - start < CHUNK_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = (($urandom_range(39) == 0) ? $urandom_range(255, 200) : $urandom_range(36, 1));
        send_record(len, 8'(len));
      end else if (pick < 80) begin
        send_record(int'($urandom_range(40, 1)), 8'($urandom_range(255)));
      end else if (pick < 88) begin
        send_beat(random_beat(CMD_DATA));
      end else if (pick < 96) begin
        send_beat(random_beat(CMD_LEARN));
      end else begin
        drain();
      end
    end
  endtask

  task automatic test_random_phase(int src_pct, int snk_pct, int first_sel);
    int c;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (c = 0; c < 4; c++) run_chunk(first_sel + c);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_mask();
    test_preset_blocks_learn();
    test_learn_zero_mask();
    test_invert();
    test_running();
    test_random_phase(34, 65, 0);
    test_random_phase(65, 34, 4);
    test_random_phase(0, 0, 8);
    drain();

    $display("%0d beats sent, %0d results checked, %0d register writes",
             beats_sent, results_seen, cfg_writes);
    $display("data beats by mode: pass %0d, pair %0d, invert %0d, running %0d",
             mode_hits[MODE_PASS], mode_hits[MODE_PAIR], mode_hits[MODE_INVERT],
             mode_hits[MODE_RUN]);
    if (errors == 0 && results_due.size() == 0) begin
      $display("tb_feed_record_descrambler: clean");
    end else begin
      if (results_due.size() != 0) $error("%0d predicted results never came", results_due.size());
      $display("tb_feed_record_descrambler: errors");
    end
    $finish;
  end

endmodule
